@@ src/arpc_pkg.sv @@
// Shared types and constants for the address region permission checker.
package arpc_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } arpc_op_t;

    localparam logic [1:0] MODE_READ  = 2'h1;
    localparam logic [1:0] MODE_WRITE = 2'h2;

    // Control part of a transaction as it moves from cell to cell.
    // bits: region mode on an append, access mask on a check.
    typedef struct packed {
        logic     valid;
        arpc_op_t op;
        logic [1:0] bits;
        logic     hit;
        logic     allowed;
        logic     status;
    } arpc_ctl_t;

endpackage

@@ src/address_region_permission_check.sv @@
// Top level: region table as a chain of entry cells with stream ports.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_      | in  | begin 64, end 64, rd 1, wr 1, query 64, mask 2, pad 4 | operation 2
//  m_      | out | allowed 1, region_hit 1, status 1, pad 5              | -
//
// One transaction enters per cycle while the chain advances; each walks the chain one
// cell per cycle, through every cell's register in order, to the output register.
// Clears and appends travel in order with checks, so every cell sees the same sequence.
// The last cell's register is the output register; while it holds an untaken result
// the whole chain and s_tready stall. Reset empties the table and the chain at once.
module address_region_permission_check #(
    parameter int MAX_REGIONS  = 64,
    parameter int ADDRESS_BITS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,  // region_begin, region_end, region_readable,
                                   // region_writable, query_address, access_mask
    input  logic [1:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // allowed, region_hit, status
);
    import arpc_pkg::*;

    localparam int INDEX_BITS = $clog2(MAX_REGIONS + 1);
    localparam logic [INDEX_BITS-1:0] COUNT_FULL = INDEX_BITS'(MAX_REGIONS);

    logic                  advance;
    logic                  accept;
    arpc_op_t              in_op;
    logic [INDEX_BITS-1:0] region_count_reg, region_count_next;
    logic                  table_full;

    arpc_ctl_t               ctl_chain    [0:MAX_REGIONS];
    logic [ADDRESS_BITS-1:0] addr_a_chain [0:MAX_REGIONS];
    logic [ADDRESS_BITS-1:0] addr_b_chain [0:MAX_REGIONS];
    logic [INDEX_BITS-1:0]   idx_chain    [0:MAX_REGIONS];

    assign in_op      = arpc_op_t'(s_tuser);
    assign table_full = region_count_reg == COUNT_FULL;
    assign advance    = !ctl_chain[MAX_REGIONS].valid || m_tready;
    assign s_tready   = advance;
    assign accept     = s_tvalid && advance;

    always_comb begin
        ctl_chain[0].valid   = s_tvalid;
        ctl_chain[0].op      = in_op;
        ctl_chain[0].hit     = 1'b0;
        ctl_chain[0].allowed = 1'b0;
        ctl_chain[0].status  = (in_op == OP_APPEND) && table_full;
        if (in_op == OP_APPEND) begin
            ctl_chain[0].bits = (s_tdata[128] ? MODE_READ : 2'b00)
                              | (s_tdata[129] ? MODE_WRITE : 2'b00);
            addr_a_chain[0]   = s_tdata[ADDRESS_BITS-1:0];
        end else begin
            ctl_chain[0].bits = s_tdata[195:194];
            addr_a_chain[0]   = s_tdata[130 +: ADDRESS_BITS];
        end
        addr_b_chain[0] = s_tdata[64 +: ADDRESS_BITS];
        idx_chain[0]    = region_count_reg;
    end

    always_comb begin
        region_count_next = region_count_reg;
        if (accept) begin
            unique case (in_op)
                OP_CLEAR:  region_count_next = '0;
                OP_APPEND: begin
                    if (!table_full) begin
                        region_count_next = region_count_reg + 1'b1;
                    end
                end
                OP_CHECK:  region_count_next = region_count_reg;
                OP_NONE:   region_count_next = region_count_reg;
                default:   region_count_next = region_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg <= '0;
        end else begin
            region_count_reg <= region_count_next;
        end
    end

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        arpc_cell #(
            .ADDRESS_BITS (ADDRESS_BITS),
            .INDEX_BITS   (INDEX_BITS),
            .CELL_INDEX   (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .ctl_in     (ctl_chain[i]),
            .addr_a_in  (addr_a_chain[i]),
            .addr_b_in  (addr_b_chain[i]),
            .idx_in     (idx_chain[i]),
            .ctl_out    (ctl_chain[i+1]),
            .addr_a_out (addr_a_chain[i+1]),
            .addr_b_out (addr_b_chain[i+1]),
            .idx_out    (idx_chain[i+1])
        );
    end

    assign m_tvalid = ctl_chain[MAX_REGIONS].valid;
    assign m_tdata  = {5'b00000, ctl_chain[MAX_REGIONS].status,
                       ctl_chain[MAX_REGIONS].hit, ctl_chain[MAX_REGIONS].allowed};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        region_count_reg <= COUNT_FULL)
        else $error("region count beyond table size");

    a_allowed_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("allowed without a region hit");

    a_status_only_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
        else $error("full-table status combined with check result");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_op == OP_CLEAR) |=> region_count_reg == '0)
        else $error("clear did not empty the table");

    a_full_append_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (in_op == OP_APPEND) && table_full |=> table_full)
        else $error("append to full table changed the count");
`endif

endmodule

@@ src/arpc_cell.sv @@
// One table entry of the region chain: holds a region and passes transactions on.
module arpc_cell #(
    parameter int ADDRESS_BITS = 64,
    parameter int INDEX_BITS   = 7,
    parameter int CELL_INDEX   = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  arpc_pkg::arpc_ctl_t      ctl_in,
    input  logic [ADDRESS_BITS-1:0]  addr_a_in,
    input  logic [ADDRESS_BITS-1:0]  addr_b_in,
    input  logic [INDEX_BITS-1:0]    idx_in,
    output arpc_pkg::arpc_ctl_t      ctl_out,
    output logic [ADDRESS_BITS-1:0]  addr_a_out,
    output logic [ADDRESS_BITS-1:0]  addr_b_out,
    output logic [INDEX_BITS-1:0]    idx_out
);
    import arpc_pkg::*;

    localparam logic [INDEX_BITS-1:0] MY_INDEX = INDEX_BITS'(CELL_INDEX);

    arpc_ctl_t               ctl_reg, ctl_next;
    logic [ADDRESS_BITS-1:0] addr_a_reg, addr_b_reg;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic [ADDRESS_BITS-1:0] begin_reg, end_reg;
    logic [1:0]              mode_reg;

    logic entry_live;
    logic in_range;
    logic do_store;

    // idx_in is the region count seen when the transaction entered
    assign entry_live = idx_in > MY_INDEX;
    assign in_range   = (addr_a_in >= begin_reg) && (addr_a_in <= end_reg);
    assign do_store   = advance && ctl_in.valid && (ctl_in.op == OP_APPEND)
                        && !ctl_in.status && (idx_in == MY_INDEX);

    always_comb begin
        ctl_next = ctl_in;
        if (ctl_in.valid && (ctl_in.op == OP_CHECK) && !ctl_in.hit
            && entry_live && in_range) begin
            ctl_next.hit     = 1'b1;
            ctl_next.allowed = |(mode_reg & ctl_in.bits);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            addr_a_reg <= addr_a_in;
            addr_b_reg <= addr_b_in;
            idx_reg    <= idx_in;
        end
        if (do_store) begin
            begin_reg <= addr_a_in;
            end_reg   <= addr_b_in;
            mode_reg  <= ctl_in.bits;
        end
    end

    assign ctl_out    = ctl_reg;
    assign addr_a_out = addr_a_reg;
    assign addr_b_out = addr_b_reg;
    assign idx_out    = idx_reg;

endmodule

@@ verif/arpc_verdict_check.sv @@
// Stream monitor and scoreboard for the address region permission checker.
module arpc_verdict_check #(
    parameter int MAX_REGIONS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,   // region_begin, region_end, region_readable,
                                    // region_writable, query_address, access_mask
    input  logic [1:0]   s_tuser,   // operation
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,   // allowed, region_hit, status
    output int           fail_count,
    output int           pending,
    output int           n_results,
    output int           n_hits,
    output int           n_allowed,
    output int           n_drops
);
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    localparam int MAX_PRINT = 40;

    typedef struct packed {
        logic allowed;
        logic hit;
        logic status;
    } verdict_t;

    verdict_t    pending_verdicts[$];

    // Shadow copy of the region table
    logic [63:0] shadow_lo[MAX_REGIONS];
    logic [63:0] shadow_hi[MAX_REGIONS];
    logic [1:0]  shadow_perm[MAX_REGIONS];
    int unsigned shadow_count;

    initial begin
        fail_count = 0;
        pending    = 0;
        n_results  = 0;
        n_hits     = 0;
        n_allowed  = 0;
        n_drops    = 0;
        shadow_count = 0;
    end

    function automatic verdict_t predict_verdict(arpc_op_t op, logic [199:0] d);
        verdict_t    v;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] q;
        logic [1:0]  perm;
        logic [1:0]  mask;
        int          i;
        v    = '0;
        lo   = d[63:0];
        hi   = d[127:64];
        perm = {d[129], d[128]};
        q    = d[193:130];
        mask = d[195:194];
        case (op)
            OP_CLEAR: begin
                shadow_count = 0;
            end
            OP_APPEND: begin
                if (shadow_count >= MAX_REGIONS) begin
                    v.status = 1'b1;
                end else begin
                    shadow_lo[shadow_count]   = lo;
                    shadow_hi[shadow_count]   = hi;
                    shadow_perm[shadow_count] = perm;
                    shadow_count++;
                end
            end
            OP_CHECK: begin
                // first containing region in table order wins
                for (i = 0; i < int'(shadow_count); i++) begin
                    if (!v.hit && q >= shadow_lo[i] && q <= shadow_hi[i]) begin
                        v.hit     = 1'b1;
                        v.allowed = |(shadow_perm[i] & mask);
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINT)
            $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            pending_verdicts.delete();
            shadow_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[1], m_tdata[2]};
                n_results++;
                if (got.hit) n_hits++;
                if (got.allowed) n_allowed++;
                if (got.status) n_drops++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected result transaction");
                end else begin
                    want = pending_verdicts.pop_front();
                    if (want.allowed !== got.allowed)
                        report_mismatch($sformatf("allowed: expected %0b, got %0b",
                                                  want.allowed, got.allowed));
                    if (want.hit !== got.hit)
                        report_mismatch($sformatf("region_hit: expected %0b, got %0b",
                                                  want.hit, got.hit));
                    if (want.status !== got.status)
                        report_mismatch($sformatf("status: expected %0b, got %0b",
                                                  want.status, got.status));
                end
            end
            if (s_tvalid && s_tready)
                pending_verdicts.insert(pending_verdicts.size(),
                                        predict_verdict(arpc_op_t'(s_tuser), s_tdata));
        end
        pending = pending_verdicts.size();
    end

endmodule

@@ verif/address_region_permission_check_tb.sv @@
// Testbench top: stimulus, flow control and verdict for the region permission checker.
module address_region_permission_check_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    localparam int MAX_REGIONS  = 64;
    localparam int TOTAL_ITEMS  = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [63:0] ALL_ONES = '1;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = OP_CLEAR;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;

    int fail_count, pending, n_results, n_hits, n_allowed, n_drops;

    int send_idle_pct = 6;
    int recv_idle_pct = 70;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int n_work        = 0;
    int n_sent        = 0;
    int stall_cnt     = 0;

    // regions appended since the last clear, used to aim queries at boundaries
    logic [63:0] known_lo[$];
    logic [63:0] known_hi[$];

    address_region_permission_check #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDRESS_BITS(64)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    arpc_verdict_check #(.MAX_REGIONS(MAX_REGIONS)) u_verdict_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .n_results (n_results),
        .n_hits    (n_hits),
        .n_allowed (n_allowed),
        .n_drops   (n_drops)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: random backpressure plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [199:0] pack_item(logic [63:0] lo, logic [63:0] hi, logic rd,
                                               logic wr, logic [63:0] q, logic [1:0] mask);
        return {4'b0, mask, q, wr, rd, hi, lo};
    endfunction

    task automatic send_item(arpc_op_t op, logic [199:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (op != OP_NONE) n_work++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic do_clear();
        known_lo.delete();
        known_hi.delete();
        send_item(OP_CLEAR, pack_item(rand64(), rand64(), 1'($urandom), 1'($urandom),
                                      rand64(), 2'($urandom)));
    endtask

    task automatic do_append(logic [63:0] lo, logic [63:0] hi, logic rd, logic wr);
        known_lo.insert(known_lo.size(), lo);
        known_hi.insert(known_hi.size(), hi);
        send_item(OP_APPEND, pack_item(lo, hi, rd, wr, rand64(), 2'($urandom)));
    endtask

    task automatic do_check(logic [63:0] q, logic [1:0] mask);
        send_item(OP_CHECK, pack_item(rand64(), rand64(), 1'($urandom), 1'($urandom), q,
                                      mask));
    endtask

    task automatic random_append();
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(3))
            0, 1: begin
                // dense low space so regions overlap
                lo = 64'($urandom_range(4095));
                hi = lo + 64'($urandom_range(300));
            end
            2: begin
                lo = rand64();
                hi = lo + (rand64() >> $urandom_range(63));  // wrap gives an empty region
            end
            default: begin
                lo = rand64();
                hi = rand64();
            end
        endcase
        do_append(lo, hi, 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [63:0] pick_query();
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        if (known_lo.size() == 0 || $urandom_range(4) == 0)
            return ($urandom_range(1) != 0) ? rand64() : 64'($urandom_range(4500));
        k  = $urandom_range(known_lo.size() - 1);
        lo = known_lo[k];
        hi = known_hi[k];
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return lo - 1;
            3: return hi + 1;
            default: begin
                if (lo > hi) return lo;
                if (hi - lo == ALL_ONES) return rand64();
                return lo + (rand64() % (hi - lo + 1));
            end
        endcase
    endfunction

    initial begin
        int  phase;
        int  new_phase;
        int  n_app;
        int  n_chk;
        int  i;
        bit  first_prog;
        arpc_op_t op;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part
        do_check(64'd0, 2'd3);                       // empty table: miss
        do_append(64'd0, 64'd0, 1'b1, 1'b0);
        do_append(ALL_ONES, ALL_ONES, 1'b0, 1'b1);
        do_append(64'd100, 64'd200, 1'b1, 1'b1);
        do_append(64'd300, 64'd250, 1'b1, 1'b1);     // begin above end: never matches
        do_append(64'd150, 64'd400, 1'b0, 1'b0);     // no permissions, overlaps previous
        do_check(64'd0, MODE_READ);
        do_check(64'd0, MODE_WRITE);
        do_check(64'd0, 2'd0);                       // hit with zero mask
        do_check(ALL_ONES, MODE_WRITE);
        do_check(ALL_ONES, MODE_READ);
        do_check(64'd150, 2'd3);                     // first match in table order
        do_check(64'd275, 2'd3);
        do_check(64'd201, MODE_READ);
        do_check(64'd99, 2'd3);
        do_check(64'd401, 2'd3);
        send_item(OP_NONE, {4'b0, {196{1'b1}}});
        send_item(OP_CLEAR, {4'b0, {196{1'b1}}});
        known_lo.delete();
        known_hi.delete();
        do_check(64'd0, 2'd3);
        do_append(64'd0, ALL_ONES, 1'b1, 1'b1);
        do_check(rand64(), 2'd3);
        wait_drained();

        // Random part: mostly clear/append/check programs, some noise
        phase      = 0;
        first_prog = 1'b1;
        while (n_work < TOTAL_ITEMS) begin
            new_phase = (n_work * 3) / TOTAL_ITEMS;
            if (new_phase != phase) begin
                wait_drained();
                phase = new_phase;
                if (phase == 1) begin
                    send_idle_pct = 70;
                    recv_idle_pct = 6;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;   // block fills while results are held off
                end
            end
            if ($urandom_range(99) < 80) begin
                if (first_prog || $urandom_range(4) != 0) do_clear();
                n_app = (first_prog || $urandom_range(3) == 0) ? $urandom_range(60, 70)
                                                               : $urandom_range(1, 12);
                first_prog = 1'b0;
                for (i = 0; i < n_app; i++) random_append();
                n_chk = $urandom_range(4, 20);
                for (i = 0; i < n_chk; i++) do_check(pick_query(), 2'($urandom));
            end else begin
                n_chk = $urandom_range(1, 6);
                for (i = 0; i < n_chk; i++) begin
                    op = arpc_op_t'($urandom_range(3));
                    send_item(op, pack_item(rand64(), rand64(), 1'($urandom), 1'($urandom),
                                            rand64(), 2'($urandom)));
                end
            end
        end

        wait_drained();
        repeat (2 * MAX_REGIONS) @(posedge aclk);

        $display("Sent %0d transactions (%0d excluding unused opcode), got %0d results.",
                 n_sent, n_work, n_results);
        $display("Region hits %0d, allowed %0d, appends dropped on full table %0d.",
                 n_hits, n_allowed, n_drops);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
